### src/iba_pkg.sv
// Shared types and constants for the indexed block allocator.
package iba_pkg;

  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam int DVD_W = 17;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EXISTS    = 3'd2,
    STAT_BAD_SIZE  = 3'd3,
    STAT_NO_BLOCKS = 3'd4,
    STAT_TOO_LARGE = 3'd5,
    STAT_NOT_FOUND = 3'd6
  } iba_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_ALLOC,
    S_DEALLOC,
    S_COMMIT,
    S_FINISH
  } iba_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_rd;
    logic scan_cmp;
    logic decide;
    logic alloc;
    logic dealloc;
    logic commit;
    logic emit;
  } iba_cmd_t;

  typedef struct packed {
    logic is_create;
    logic div_done;
    logic scan_hit;
    logic scan_last;
    logic go_alloc;
    logic go_free;
    logic alloc_done;
    logic free_done;
    logic out_busy;
  } iba_sts_t;

endpackage

### src/iba_if.sv
// Request and result channel interfaces of the indexed block allocator.
interface iba_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] file_key;
  logic [15:0] file_size;
  modport source (output valid, action, file_key, file_size, input ready);
  modport sink (input valid, action, file_key, file_size, output ready);
endinterface

interface iba_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] file_id;
  logic [7:0] index_block;
  logic [5:0] data_blocks;
  logic [8:0] free_blocks;
  logic [4:0] live_files;
  modport source (output valid, status, file_id, index_block, data_blocks, free_blocks,
                  live_files, input ready);
  modport sink (input valid, status, file_id, index_block, data_blocks, free_blocks,
                live_files, output ready);
endinterface

### src/indexed_block_allocator.sv
// Indexed block allocator top level.
// Steps: accept, block count (create only), then a read and a compare per file slot
// scanned, decide, ring and index table transfers on success, commit and finish.
// One request is in flight at a time; the result register lets a new request in.
// Synchronous active-low reset restores the full ring, the full ID stack and no files;
// no memory clearing pass is needed.
module indexed_block_allocator #(
  parameter int TOTAL_BLOCK_COUNT = 256,
  parameter int BLOCK_BYTES       = 512,
  parameter int FILE_SLOTS        = 16,
  parameter int INDEX_ENTRIES     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  iba_in_if.sink      in_chan,
  iba_out_if.source   out_chan
);

  iba_pkg::iba_cmd_t cmd;
  iba_pkg::iba_sts_t sts;

  iba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iba_dp #(
    .TOTAL_BLOCK_COUNT (TOTAL_BLOCK_COUNT),
    .BLOCK_BYTES       (BLOCK_BYTES),
    .FILE_SLOTS        (FILE_SLOTS),
    .INDEX_ENTRIES     (INDEX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_chan.action),
    .in_file_key     (in_chan.file_key),
    .in_file_size    (in_chan.file_size),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_file_id     (out_chan.file_id),
    .out_index_block (out_chan.index_block),
    .out_data_blocks (out_chan.data_blocks),
    .out_free_blocks (out_chan.free_blocks),
    .out_live_files  (out_chan.live_files)
  );

endmodule

### src/iba_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module iba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  iba_pkg::iba_sts_t sts,
  output iba_pkg::iba_cmd_t cmd
);

  iba_pkg::iba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      iba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = iba_pkg::S_DIVIDE;
        end
      end
      iba_pkg::S_DIVIDE: begin
        if (!sts.is_create || sts.div_done) begin
          state_nxt = iba_pkg::S_SCAN_RD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      iba_pkg::S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = iba_pkg::S_SCAN_CMP;
      end
      iba_pkg::S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          state_nxt = iba_pkg::S_DECIDE;
        end else begin
          state_nxt = iba_pkg::S_SCAN_RD;
        end
      end
      iba_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (sts.go_alloc) begin
          state_nxt = iba_pkg::S_ALLOC;
        end else if (sts.go_free) begin
          state_nxt = iba_pkg::S_DEALLOC;
        end else begin
          state_nxt = iba_pkg::S_COMMIT;
        end
      end
      iba_pkg::S_ALLOC: begin
        cmd.alloc = 1'b1;
        if (sts.alloc_done) begin
          state_nxt = iba_pkg::S_COMMIT;
        end
      end
      iba_pkg::S_DEALLOC: begin
        cmd.dealloc = 1'b1;
        if (sts.free_done) begin
          state_nxt = iba_pkg::S_COMMIT;
        end
      end
      iba_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = iba_pkg::S_FINISH;
      end
      iba_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = iba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = iba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/iba_dp.sv
// Datapath with the free block ring, the ID stack, the file table and the index table.
module iba_dp #(
  parameter int TOTAL_BLOCK_COUNT = 256,
  parameter int BLOCK_BYTES       = 512,
  parameter int FILE_SLOTS        = 16,
  parameter int INDEX_ENTRIES     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iba_pkg::iba_cmd_t cmd,
  output iba_pkg::iba_sts_t sts,
  input  logic              in_action,
  input  logic [63:0]       in_file_key,
  input  logic [15:0]       in_file_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [3:0]        out_file_id,
  output logic [7:0]        out_index_block,
  output logic [5:0]        out_data_blocks,
  output logic [8:0]        out_free_blocks,
  output logic [4:0]        out_live_files
);

  localparam int DVD_W    = iba_pkg::DVD_W;
  localparam int SLOT_W   = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int DEP_W    = $clog2(FILE_SLOTS + 1);
  localparam int RA_W     = $clog2(TOTAL_BLOCK_COUNT);
  localparam int RC_W     = $clog2(TOTAL_BLOCK_COUNT + 1);
  localparam int CNT_W    = $clog2(INDEX_ENTRIES + 1);
  localparam int ISS_W    = CNT_W + 1;
  localparam int IT_DEPTH = FILE_SLOTS * INDEX_ENTRIES;
  localparam int IT_AW    = (IT_DEPTH > 1) ? $clog2(IT_DEPTH) : 1;
  localparam int BB_LG    = $clog2(BLOCK_BYTES);
  localparam int RCP_SH   = DVD_W + BB_LG;
  localparam int RCP_W    = DVD_W + 2;
  localparam int PRD_W    = DVD_W + RCP_W;
  localparam longint RCP_L = ((longint'(1) << RCP_SH) + longint'(BLOCK_BYTES) - longint'(1))
                             / longint'(BLOCK_BYTES);

  localparam logic [RCP_W-1:0] RCP_C     = RCP_W'(RCP_L);
  localparam logic [DVD_W-1:0] BB_M1_C   = DVD_W'(BLOCK_BYTES - 1);
  localparam logic [DVD_W-1:0] IE_C      = DVD_W'(INDEX_ENTRIES);
  localparam logic [RA_W-1:0]  RING_LAST = RA_W'(TOTAL_BLOCK_COUNT - 1);
  localparam logic [RC_W-1:0]  RING_FULL = RC_W'(TOTAL_BLOCK_COUNT);
  localparam logic [DEP_W-1:0] SLOTS_C   = DEP_W'(FILE_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FILE_SLOTS - 1);

  // Request registers.
  logic              req_act_r;
  logic [63:0]       req_key_r;
  logic [15:0]       req_size_r;

  // Block count by reciprocal multiplication.
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic              div_done_r;
  logic [PRD_W-1:0]  prd;

  // File table.
  logic [FILE_SLOTS-1:0] entry_valid_r;
  logic [63:0]       key_mem   [FILE_SLOTS];
  logic [CNT_W-1:0]  cnt_mem   [FILE_SLOTS];
  logic [RA_W-1:0]   iblk_mem  [FILE_SLOTS];
  logic [SLOT_W-1:0] scan_idx_r;
  logic [63:0]       key_q_r;
  logic [CNT_W-1:0]  cnt_q_r;
  logic [RA_W-1:0]   iblk_q_r;
  logic              vld_q_r;
  logic              found_r;
  logic [SLOT_W-1:0] fslot_r;
  logic [CNT_W-1:0]  fcnt_r;
  logic [RA_W-1:0]   fiblk_r;

  // ID stack.
  logic [SLOT_W-1:0] stack_r [FILE_SLOTS];
  logic [DEP_W-1:0]  depth_r;
  logic [SLOT_W-1:0] stack_top;

  // Free block ring.
  logic [RA_W-1:0]   ring_mem [TOTAL_BLOCK_COUNT];
  logic [RA_W-1:0]   head_r, head_nxt;
  logic [RA_W-1:0]   tail_r, tail_nxt;
  logic [RC_W-1:0]   count_r, count_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [RA_W-1:0]   ring_q_r;
  logic [RA_W-1:0]   rd_addr_r;
  logic              rd_wr_r;
  logic [RA_W-1:0]   pop_data;

  // Index table.
  logic [RA_W-1:0]   it_mem [IT_DEPTH];
  logic [RA_W-1:0]   it_q_r;
  logic [IT_AW-1:0]  it_base;

  // Per request control.
  iba_pkg::iba_status_t status_r, dec_status;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  need_r;
  logic [RA_W-1:0]   iblk_r;
  logic [ISS_W-1:0]  iss_r;
  logic [ISS_W-1:0]  wr_r;
  logic              pend_r;
  logic              tail_done_r;
  logic [ISS_W-1:0]  iss_lim;
  logic              pop_issue;
  logic              it_issue;
  logic              push_blk;
  logic              push_idx;
  logic              push_ok;
  logic [RA_W-1:0]   push_data;
  logic              is_create;
  logic              commit_ok;

  // Result register.
  logic              out_valid_r;
  iba_pkg::iba_status_t out_status_r;
  logic [SLOT_W-1:0] out_fid_r;
  logic [RA_W-1:0]   out_iblk_r;
  logic [CNT_W-1:0]  out_ndata_r;
  logic [RC_W-1:0]   out_free_r;
  logic [DEP_W-1:0]  out_live_r;

  assign is_create = (req_act_r == iba_pkg::ACT_CREATE);
  assign prd       = PRD_W'(dvd_r) * PRD_W'(RCP_C);
  assign stack_top = SLOT_W'(depth_r - DEP_W'(1));
  assign it_base   = IT_AW'(slot_r) * IT_AW'(INDEX_ENTRIES);
  assign iss_lim   = ISS_W'(need_r) + ISS_W'(1);
  assign pop_data  = rd_wr_r ? ring_q_r : rd_addr_r;
  assign commit_ok = cmd.commit && (status_r == iba_pkg::STAT_OK);

  assign pop_issue = cmd.alloc && (iss_r < iss_lim);
  assign it_issue  = cmd.dealloc && (iss_r < ISS_W'(need_r));
  assign push_idx  = cmd.dealloc && pend_r;
  assign push_blk  = cmd.dealloc && !pend_r && (iss_r == ISS_W'(need_r)) && !tail_done_r;
  assign push_ok   = (push_idx || push_blk) && (count_r < RING_FULL);
  assign push_data = push_idx ? it_q_r : iblk_r;

  always_comb begin
    priority if (is_create) begin
      priority if (depth_r == '0) begin
        dec_status = iba_pkg::STAT_FULL;
      end else if (found_r) begin
        dec_status = iba_pkg::STAT_EXISTS;
      end else if (req_size_r == '0) begin
        dec_status = iba_pkg::STAT_BAD_SIZE;
      end else if ((DVD_W + 1)'(count_r) < ((DVD_W + 1)'(quo_r) + (DVD_W + 1)'(1))) begin
        dec_status = iba_pkg::STAT_NO_BLOCKS;
      end else if (quo_r > IE_C) begin
        dec_status = iba_pkg::STAT_TOO_LARGE;
      end else begin
        dec_status = iba_pkg::STAT_OK;
      end
    end else begin
      dec_status = found_r ? iba_pkg::STAT_OK : iba_pkg::STAT_NOT_FOUND;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    wrapped_nxt = wrapped_r;
    if (pop_issue) begin
      head_nxt  = (head_r == RING_LAST) ? '0 : head_r + RA_W'(1);
      count_nxt = count_r - RC_W'(1);
    end else if (push_ok) begin
      tail_nxt  = (tail_r == RING_LAST) ? '0 : tail_r + RA_W'(1);
      count_nxt = count_r + RC_W'(1);
      if (tail_r == RING_LAST) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  assign sts.is_create  = is_create;
  assign sts.div_done   = div_done_r;
  assign sts.scan_hit   = vld_q_r && (key_q_r == req_key_r);
  assign sts.scan_last  = (scan_idx_r == SLOT_LAST);
  assign sts.go_alloc   = is_create && (dec_status == iba_pkg::STAT_OK);
  assign sts.go_free    = !is_create && (dec_status == iba_pkg::STAT_OK);
  assign sts.alloc_done = (iss_r == iss_lim) && !pend_r;
  assign sts.free_done  = tail_done_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= RING_FULL;
      wrapped_r     <= 1'b0;
      depth_r       <= SLOTS_C;
      entry_valid_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < FILE_SLOTS; i++) begin
        stack_r[i] <= SLOT_W'(FILE_SLOTS - 1 - i);
      end
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      wrapped_r <= wrapped_nxt;
      if (commit_ok) begin
        if (is_create) begin
          entry_valid_r[slot_r] <= 1'b1;
          depth_r               <= depth_r - DEP_W'(1);
        end else begin
          entry_valid_r[slot_r] <= 1'b0;
          if (depth_r < SLOTS_C) begin
            stack_r[SLOT_W'(depth_r)] <= slot_r;
            depth_r                   <= depth_r + DEP_W'(1);
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act_r  <= in_action;
      req_key_r  <= in_file_key;
      req_size_r <= in_file_size;
      dvd_r      <= DVD_W'(in_file_size) + BB_M1_C;
      quo_r      <= '0;
      div_done_r <= 1'b0;
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end
    if (cmd.div_step) begin
      quo_r      <= DVD_W'(prd >> RCP_SH);
      div_done_r <= 1'b1;
    end
    if (cmd.scan_rd) begin
      vld_q_r <= entry_valid_r[scan_idx_r];
    end
    if (cmd.scan_cmp) begin
      if (sts.scan_hit) begin
        found_r <= 1'b1;
        fslot_r <= scan_idx_r;
        fcnt_r  <= cnt_q_r;
        fiblk_r <= iblk_q_r;
      end else if (!sts.scan_last) begin
        scan_idx_r <= scan_idx_r + SLOT_W'(1);
      end
    end
    if (cmd.decide) begin
      status_r    <= dec_status;
      slot_r      <= is_create ? stack_r[stack_top] : fslot_r;
      need_r      <= is_create ? CNT_W'(quo_r) : fcnt_r;
      iblk_r      <= fiblk_r;
      iss_r       <= '0;
      wr_r        <= '0;
      pend_r      <= 1'b0;
      tail_done_r <= 1'b0;
    end
    if (cmd.alloc || cmd.dealloc) begin
      pend_r <= pop_issue || it_issue;
      if (pop_issue || it_issue) begin
        iss_r <= iss_r + ISS_W'(1);
      end
    end
    if (cmd.alloc && pend_r) begin
      if (wr_r == '0) begin
        iblk_r <= pop_data;
      end
      wr_r <= wr_r + ISS_W'(1);
    end
    if (push_blk) begin
      tail_done_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_fid_r    <= (status_r == iba_pkg::STAT_OK) ? slot_r : '0;
      out_iblk_r   <= (status_r == iba_pkg::STAT_OK) ? iblk_r : '0;
      out_ndata_r  <= (status_r == iba_pkg::STAT_OK) ? need_r : '0;
      out_free_r   <= count_r;
      out_live_r   <= SLOTS_C - depth_r;
    end
  end

  // File table memories.
  always_ff @(posedge clk) begin
    if (commit_ok && is_create) begin
      key_mem[slot_r]  <= req_key_r;
      cnt_mem[slot_r]  <= need_r;
      iblk_mem[slot_r] <= iblk_r;
    end
    if (cmd.scan_rd) begin
      key_q_r  <= key_mem[scan_idx_r];
      cnt_q_r  <= cnt_mem[scan_idx_r];
      iblk_q_r <= iblk_mem[scan_idx_r];
    end
  end

  // Free block ring memory.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      ring_mem[tail_r] <= push_data;
    end
    if (pop_issue) begin
      ring_q_r  <= ring_mem[head_r];
      rd_addr_r <= head_r;
      rd_wr_r   <= wrapped_r || (head_r < tail_r);
    end
  end

  // Index table memory.
  always_ff @(posedge clk) begin
    if (cmd.alloc && pend_r && (wr_r != '0)) begin
      it_mem[it_base + IT_AW'(wr_r - ISS_W'(1))] <= pop_data;
    end
    if (it_issue) begin
      it_q_r <= it_mem[it_base + IT_AW'(iss_r)];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_file_id     = 4'(out_fid_r);
  assign out_index_block = 8'(out_iblk_r);
  assign out_data_blocks = 6'(out_ndata_r);
  assign out_free_blocks = 9'(out_free_r);
  assign out_live_files  = 5'(out_live_r);

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RING_FULL) else $error("free block count above ring size");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SLOTS_C) else $error("ID stack depth above slot count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_issue |-> count_r != '0) else $error("block taken from an empty ring");
  a_create_id: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_ok && is_create) |-> depth_r != '0) else $error("create without a free ID");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r) else $error("result not presented after emit");
`endif

endmodule
